>>> src/swts_pkg.sv
package swts_pkg;

	// item field widths
	localparam int MODE_W = 3;
	localparam int ID_W   = 4;
	localparam int PER_W  = 31;

	// time, start order and firing count widths
	localparam int TIME_W     = 64;
	localparam int ORD_W      = 32;
	localparam int MAX_FIRE   = 16;
	localparam int FIRE_CNT_W = 5;

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SETUP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CHANGE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ONCE   = 3'd5;

endpackage

>>> src/swts_if.sv
interface swts_cmd_if;
	import swts_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ID_W-1:0]   timer_id;
	logic [PER_W-1:0]  period_ms;
	logic              repeat_flag;

	modport source (output valid, mode, timer_id, period_ms, repeat_flag, input ready);
	modport sink (input valid, mode, timer_id, period_ms, repeat_flag, output ready);
endinterface

interface swts_rsp_if;
	import swts_pkg::*;

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] fired_id;
	logic            fired;
	logic            last;

	modport source (output valid, fired_id, fired, last, input ready);
	modport sink (input valid, fired_id, fired, last, output ready);
endinterface

>>> src/swts_ram.sv
module swts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/software_timer_scheduler_top.sv
// channel | dir | payload                                   | accepted when
// cmd     | in  | mode, timer_id, period_ms, repeat_flag    | cmd.valid && cmd.ready
// rsp     | out | fired_id, fired, last                     | rsp.valid && rsp.ready
//
// Set up, stop and bad-id items go straight to the result step; start, change and once items
// first read the period and write the deadline. A tick makes a due pass, then up to 16 firings,
// each a selection pass and a fire step; the due pass and each selection pass read one deadline a cycle.
// Reset clears time, counters and flags at once; the deadline memory needs no clearing pass.
// A result waits in an output register, so the next item is taken while it is held;
// an item stalls in its result steps only while that register is full and not being taken.
module software_timer_scheduler_top #(
	parameter int NUM_TIMERS = 16
) (
	input logic        clk,
	input logic        arst_n,
	swts_cmd_if.sink   cmd,
	swts_rsp_if.source rsp
);
	import swts_pkg::*;

	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
	localparam logic [FIRE_CNT_W-1:0] LAST_FIRE = FIRE_CNT_W'(MAX_FIRE - 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DUE  = 9'b000000010,
		ST_SEL  = 9'b000000100,
		ST_EMIT = 9'b000001000,
		ST_FRD  = 9'b000010000,
		ST_FWR  = 9'b000100000,
		ST_ARD  = 9'b001000000,
		ST_AWR  = 9'b010000000,
		ST_RESP = 9'b100000000
	} state_t;

	state_t state_q;

	logic [TIME_W-1:0]     now_q;
	logic [ORD_W-1:0]      cnt_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic [NUM_TIMERS-1:0] periodic_q;
	logic [NUM_TIMERS-1:0] pvld_q;
	logic [NUM_TIMERS-1:0] due_q;

	logic [IDX_W-1:0]      scan_addr_q;
	logic                  scan_on_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	logic                  best_vld_q;
	logic [TIME_W-1:0]     best_dl_q;
	logic [ORD_W-1:0]      best_age_q;
	logic [IDX_W-1:0]      best_idx_q;

	logic                  pend_vld_q;
	logic [ID_W-1:0]       pend_id_q;
	logic [FIRE_CNT_W-1:0] n_q;

	logic                  tick_q;
	logic [ID_W-1:0]       id_q;

	logic                  out_vld_q;
	logic [ID_W-1:0]       out_id_q;
	logic                  out_fired_q;
	logic                  out_last_q;

	logic                  accept;
	logic                  cmd_tick;
	logic                  cmd_id_ok;
	logic [IDX_W-1:0]      cmd_idx;
	logic [IDX_W-1:0]      id_idx;
	logic [IDX_W-1:0]      arm_idx;

	logic [TIME_W+ORD_W-1:0] tm_wdata;
	logic [TIME_W+ORD_W-1:0] tm_rdata;
	logic                    tm_we;
	logic [TIME_W-1:0]       rd_dl;
	logic [ORD_W-1:0]        rd_ord;

	logic                  per_we;
	logic [IDX_W-1:0]      per_raddr;
	logic [PER_W-1:0]      per_rdata;
	logic [PER_W-1:0]      period_eff;

	logic [TIME_W-1:0]     add_b;
	logic [TIME_W-1:0]     sum;
	logic [TIME_W-1:0]     cmp_a;
	logic [TIME_W-1:0]     cmp_b;
	logic                  cmp_lt;
	logic                  cmp_eq;
	logic [ORD_W-1:0]      age_c;
	logic                  cand_ok;
	logic                  take;
	logic                  scan_end;
	logic                  scan_start;
	logic                  can_emit;

	logic                  emit_vld;
	logic [ID_W-1:0]       emit_id;
	logic                  emit_fired;
	logic                  emit_last;

	// handshake and addressed timer
	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && (state_q == ST_IDLE);
	assign cmd_tick  = (cmd.mode == MODE_TICK);
	assign cmd_id_ok = (32'(cmd.timer_id) < NUM_TIMERS);
	assign cmd_idx   = IDX_W'(cmd.timer_id);
	assign id_idx    = IDX_W'(id_q);
	assign arm_idx   = (state_q == ST_AWR) ? id_idx : best_idx_q;

	// deadline and start order memory
	assign tm_we    = (state_q == ST_AWR) || ((state_q == ST_FWR) && periodic_q[best_idx_q]);
	assign tm_wdata = {cnt_q, sum};
	assign rd_dl    = tm_rdata[TIME_W-1:0];
	assign rd_ord   = tm_rdata[TIME_W +: ORD_W];

	swts_ram #(
		.WIDTH (TIME_W + ORD_W),
		.DEPTH (NUM_TIMERS)
	) u_tm_ram (
		.clk   (clk),
		.we    (tm_we),
		.waddr (arm_idx),
		.wdata (tm_wdata),
		.raddr (scan_addr_q),
		.rdata (tm_rdata)
	);

	// period memory, written by set up, change and once items
	always_comb begin
		per_we = 1'b0;
		if (accept && !cmd_tick && cmd_id_ok) begin
			case (cmd.mode)
				MODE_SETUP, MODE_CHANGE, MODE_ONCE: per_we = 1'b1;
				default: per_we = 1'b0;
			endcase
		end
	end

	assign per_raddr  = (state_q == ST_FRD) ? best_idx_q : id_idx;
	assign period_eff = pvld_q[arm_idx] ? per_rdata : '0;

	swts_ram #(
		.WIDTH (PER_W),
		.DEPTH (NUM_TIMERS)
	) u_per_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (cmd_idx),
		.wdata (cmd.period_ms),
		.raddr (per_raddr),
		.rdata (per_rdata)
	);

	// shared time adder: tick increment or timer deadline (start, change, once or rearm)
	assign add_b = (state_q == ST_IDLE) ? TIME_W'(1) : TIME_W'(period_eff);
	assign sum   = now_q + add_b;

	// shared comparator: due test against now, or candidate against best
	assign cmp_a  = (state_q == ST_DUE) ? now_q : rd_dl;
	assign cmp_b  = (state_q == ST_DUE) ? rd_dl : best_dl_q;
	assign cmp_lt = (cmp_a < cmp_b);
	assign cmp_eq = (cmp_a == cmp_b);

	// earlier deadline wins, equal deadlines go to the older start
	assign age_c    = cnt_q - rd_ord;
	assign cand_ok  = (state_q == ST_SEL) && rd_vld_s1 && due_q[rd_idx_s1];
	assign take     = !best_vld_q || cmp_lt || (cmp_eq && (age_c > best_age_q));
	assign scan_end = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);

	assign scan_start = (accept && cmd_tick)
		|| ((state_q == ST_DUE) && scan_end)
		|| ((state_q == ST_FWR) && (n_q != LAST_FIRE));

	// result selection
	assign can_emit = !out_vld_q || rsp.ready;

	always_comb begin
		emit_vld   = 1'b0;
		emit_id    = '0;
		emit_fired = 1'b0;
		emit_last  = 1'b1;
		case (state_q)
			ST_EMIT: begin
				emit_vld   = can_emit;
				emit_id    = pend_id_q;
				emit_fired = 1'b1;
				emit_last  = 1'b0;
			end
			ST_RESP: begin
				emit_vld = can_emit;
				if (!tick_q) begin
					emit_id = id_q;
				end else if (pend_vld_q) begin
					emit_id    = pend_id_q;
					emit_fired = 1'b1;
				end
			end
			default: emit_vld = 1'b0;
		endcase
	end

	// sequencer and timer flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			cnt_q       <= '0;
			active_q    <= '0;
			periodic_q  <= '0;
			pvld_q      <= '0;
			due_q       <= '0;
			scan_addr_q <= '0;
			scan_on_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			best_vld_q  <= 1'b0;
			pend_vld_q  <= 1'b0;
			n_q         <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			// scan address walk, one memory read per cycle
			rd_vld_s1 <= scan_on_q;
			if (scan_on_q) begin
				if (scan_addr_q == LAST_IDX) begin
					scan_on_q <= 1'b0;
				end else begin
					scan_addr_q <= scan_addr_q + 1'b1;
				end
			end
			if (scan_start) begin
				scan_on_q   <= 1'b1;
				scan_addr_q <= '0;
				best_vld_q  <= 1'b0;
			end

			if (emit_vld) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd_tick) begin
							now_q      <= sum;
							n_q        <= '0;
							pend_vld_q <= 1'b0;
							state_q    <= ST_DUE;
						end else begin
							state_q <= ST_RESP;
							if (cmd_id_ok) begin
								case (cmd.mode)
									MODE_SETUP: begin
										pvld_q[cmd_idx]     <= 1'b1;
										periodic_q[cmd_idx] <= cmd.repeat_flag;
										active_q[cmd_idx]   <= 1'b0;
									end
									MODE_START: state_q <= ST_ARD;
									MODE_STOP: active_q[cmd_idx] <= 1'b0;
									MODE_CHANGE: begin
										pvld_q[cmd_idx] <= 1'b1;
										state_q         <= ST_ARD;
									end
									MODE_ONCE: begin
										pvld_q[cmd_idx]     <= 1'b1;
										periodic_q[cmd_idx] <= 1'b0;
										state_q             <= ST_ARD;
									end
									default: state_q <= ST_RESP;
								endcase
							end
						end
					end
				end
				ST_DUE: begin
					if (rd_vld_s1) begin
						due_q[rd_idx_s1] <= active_q[rd_idx_s1] && !cmp_lt;
					end
					if (scan_end) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (cand_ok && take) begin
						best_vld_q <= 1'b1;
					end
					if (scan_end) begin
						if (best_vld_q || cand_ok) begin
							state_q <= pend_vld_q ? ST_EMIT : ST_FRD;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_EMIT: begin
					if (can_emit) begin
						state_q <= ST_FRD;
					end
				end
				ST_FRD: state_q <= ST_FWR;
				ST_FWR: begin
					if (periodic_q[best_idx_q]) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						active_q[best_idx_q] <= 1'b0;
					end
					due_q[best_idx_q] <= 1'b0;
					pend_vld_q        <= 1'b1;
					n_q               <= n_q + 1'b1;
					state_q           <= (n_q == LAST_FIRE) ? ST_RESP : ST_SEL;
				end
				ST_ARD: state_q <= ST_AWR;
				ST_AWR: begin
					active_q[id_idx] <= 1'b1;
					cnt_q            <= cnt_q + 1'b1;
					state_q          <= ST_RESP;
				end
				ST_RESP: begin
					if (can_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_addr_q;
		if (accept) begin
			tick_q <= cmd_tick;
			id_q   <= cmd.timer_id;
		end
		if (cand_ok && take) begin
			best_dl_q  <= rd_dl;
			best_age_q <= age_c;
			best_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_FWR) begin
			pend_id_q <= ID_W'(best_idx_q);
		end
		if (emit_vld) begin
			out_id_q    <= emit_id;
			out_fired_q <= emit_fired;
			out_last_q  <= emit_last;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.fired_id = out_id_q;
	assign rsp.fired    = out_fired_q;
	assign rsp.last     = out_last_q;

	// firing count never passes the per-tick limit
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_q) <= MAX_FIRE)
		else $error("firing count above limit");

	// a fired timer was selected and still due
	a_fire_due: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWR) |-> (best_vld_q && due_q[best_idx_q]))
		else $error("firing a timer that is not due");

	// ready is low in the cycle after every accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("ready right after accept");

	// a fired result that is not last only comes from the emit step
	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_vld && !emit_last) |-> ((state_q == ST_EMIT) && pend_vld_q && tick_q))
		else $error("non-final result outside a tick");

endmodule
